// ----- rtl/core/aesc_pkg.sv -----
// Package for the escape sequence stripper: scan mode codes, character
// constants and the step result struct. No dependencies.
package aesc_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_AFTERCR = 3'd1,
		MODE_ESC     = 3'd2,
		MODE_CSI     = 3'd3,
		MODE_OSC     = 3'd4,
		MODE_OSCESC  = 3'd5,
		MODE_SKIP    = 3'd6
	} scan_mode_t;

	localparam logic [7:0] CH_BEL       = 8'h07;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_ESC       = 8'h1b;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_PARAM_MAX = 8'h3f;
	localparam logic [7:0] CH_FINAL_MIN = 8'h40;
	localparam logic [7:0] CH_FINAL_MAX = 8'h7e;
	localparam logic [7:0] CH_CSI_INTRO = 8'h5b;
	localparam logic [7:0] CH_OSC_INTRO = 8'h5d;
	localparam logic [7:0] CH_BSLASH    = 8'h5c;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_STAR      = 8'h2a;
	localparam logic [7:0] CH_PLUS      = 8'h2b;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_PERCENT   = 8'h25;

	typedef struct packed {
		logic       keep;
		logic [7:0] out_byte;
		scan_mode_t next_mode;
	} scan_res_t;

endpackage

// ----- rtl/core/aesc_if.sv -----
// Stream interfaces for the escape sequence stripper: raw byte beats in,
// cleaned byte beats out. No dependencies.
interface aesc_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       buffer_end;

	modport source (output valid, output in_byte, output buffer_end, input ready);
	modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface aesc_clean_if;
	logic       valid;
	logic       ready;
	logic       keep;
	logic [7:0] out_byte;
	logic       buffer_end_out;

	modport source (output valid, output keep, output out_byte, output buffer_end_out,
		input ready);
	modport sink (input valid, input keep, input out_byte, input buffer_end_out,
		output ready);
endinterface

// ----- rtl/core/aesc_scan.sv -----
// Byte classifier of the escape sequence stripper: one step of the scan
// state machine. Depends on aesc_pkg.
module aesc_scan
	import aesc_pkg::*;
(
	input  scan_mode_t  mode,
	input  logic [7:0]  cur_byte,
	output scan_res_t   res
);

	scan_res_t text_res;
	logic      is_osc_end;
	logic      is_osc_esc;

	// Handle a byte as ordinary text.
	always_comb begin
		text_res.keep      = 1'b0;
		text_res.out_byte  = 8'h00;
		text_res.next_mode = MODE_NORMAL;
		if (cur_byte == CH_ESC) begin
			text_res.next_mode = MODE_ESC;
		end else if (cur_byte == CH_CR) begin
			text_res.keep      = 1'b1;
			text_res.out_byte  = CH_LF;
			text_res.next_mode = MODE_AFTERCR;
		end else if (cur_byte == CH_TAB || cur_byte == CH_LF || cur_byte >= CH_SPACE) begin
			text_res.keep      = 1'b1;
			text_res.out_byte  = cur_byte;
		end
	end

	assign is_osc_end = (cur_byte == CH_BEL);
	assign is_osc_esc = (cur_byte == CH_ESC);

	always_comb begin
		res.keep      = 1'b0;
		res.out_byte  = 8'h00;
		res.next_mode = MODE_NORMAL;
		unique case (mode)
			MODE_AFTERCR: begin
				// drop the LF of a CR LF pair
				if (cur_byte != CH_LF) begin
					res = text_res;
				end
			end
			MODE_ESC: begin
				priority if (cur_byte == CH_CSI_INTRO) begin
					res.next_mode = MODE_CSI;
				end else if (cur_byte == CH_OSC_INTRO) begin
					res.next_mode = MODE_OSC;
				end else if (cur_byte == CH_LPAREN || cur_byte == CH_RPAREN ||
					cur_byte == CH_STAR || cur_byte == CH_PLUS ||
					cur_byte == CH_HASH || cur_byte == CH_PERCENT) begin
					res.next_mode = MODE_SKIP;
				end else begin
					res.next_mode = MODE_NORMAL;
				end
			end
			MODE_CSI: begin
				priority if (cur_byte >= CH_FINAL_MIN && cur_byte <= CH_FINAL_MAX) begin
					res.next_mode = MODE_NORMAL;
				end else if (cur_byte >= CH_SPACE && cur_byte <= CH_PARAM_MAX) begin
					res.next_mode = MODE_CSI;
				end else begin
					// malformed: end the sequence, treat the byte as text
					res = text_res;
				end
			end
			MODE_OSC, MODE_OSCESC: begin
				priority if (mode == MODE_OSCESC && cur_byte == CH_BSLASH) begin
					res.next_mode = MODE_NORMAL;
				end else if (is_osc_end) begin
					res.next_mode = MODE_NORMAL;
				end else if (is_osc_esc) begin
					res.next_mode = MODE_OSCESC;
				end else begin
					res.next_mode = MODE_OSC;
				end
			end
			MODE_SKIP: begin
				res.next_mode = MODE_NORMAL;
			end
			default: begin
				res = text_res;
			end
		endcase
	end

endmodule

// ----- rtl/core/ansi_escape_stripper_unit.sv -----
// Top level of the escape sequence stripper: input register, scan step and
// result register. Depends on aesc_pkg, aesc_if and aesc_scan.
//
// Strips ANSI escape sequences from a byte stream. Every raw beat yields
// exactly one clean beat: keep says whether out_byte carries text (out_byte
// is zero otherwise) and buffer_end_out copies the beat's buffer_end. CSI,
// OSC, charset designator and two-byte escapes are removed, CR comes out as
// LF, an LF right after a CR is dropped, and control bytes other than tab
// and LF are dropped. The byte after an end-marked byte is scanned in normal
// text mode. Throughput is one byte per clock while clean.ready is high; a
// byte is held in the input register and its clean beat is offered from the
// result register. The rate is set by the scan mode register, which is read
// and written in the same cycle as the byte it steers.
// raw.ready is high whenever the input register is empty or moves on, so one
// more byte can be taken while a finished beat waits on clean.ready.
module ansi_escape_stripper_unit
	import aesc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	aesc_raw_if.sink           raw,
	aesc_clean_if.source       clean
);

	// input register
	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       buffer_end_s1;

	// result register
	logic       valid_s2;
	logic       keep_s2;
	logic [7:0] out_byte_s2;
	logic       buffer_end_s2;

	scan_mode_t scan_mode_q;
	scan_res_t  step_res;
	logic       adv_s2;

	// Advance into the result register when it is empty or being drained.
	assign adv_s2    = valid_s1 && (!valid_s2 || clean.ready);
	assign raw.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	// Payload needs no reset; load on every accepted beat.
	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			in_byte_s1    <= raw.in_byte;
			buffer_end_s1 <= raw.buffer_end;
		end
	end

	aesc_scan u_scan (
		.mode     (scan_mode_q),
		.cur_byte (in_byte_s1),
		.res      (step_res)
	);

	// Advance the scan mode with each byte; an end-marked byte sends it
	// back to normal text so unfinished sequences drop out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q <= MODE_NORMAL;
		end else if (adv_s2) begin
			scan_mode_q <= buffer_end_s1 ? MODE_NORMAL : step_res.next_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || clean.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the result while the sink stalls.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			keep_s2       <= step_res.keep;
			out_byte_s2   <= step_res.out_byte;
			buffer_end_s2 <= buffer_end_s1;
		end
	end

	assign clean.valid          = valid_s2;
	assign clean.keep           = keep_s2;
	assign clean.out_byte       = out_byte_s2;
	assign clean.buffer_end_out = buffer_end_s2;

endmodule

// ----- rtl/core/aesc_checker.sv -----
// Port checker for the escape sequence stripper, bound to the top level.
// Depends on aesc_pkg and ansi_escape_stripper_unit.
module aesc_checker
	import aesc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       clean_valid,
	input logic       clean_ready,
	input logic       clean_keep,
	input logic [7:0] clean_out_byte
);

	// A stalled beat stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clean_valid && !clean_ready |=> clean_valid)
		else $error("clean beat withdrawn while stalled");

	// A stalled beat's byte and keep flag do not change.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clean_valid && !clean_ready |=> $stable(clean_out_byte) && $stable(clean_keep))
		else $error("clean beat changed while stalled");

	// Dropped bytes carry a zero byte.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		clean_valid && !clean_keep |-> clean_out_byte == 8'h00)
		else $error("dropped beat carries a nonzero byte");

	// Kept bytes are tab, LF or at or above space; never CR or ESC.
	a_kept_legal: assert property (@(posedge clk) disable iff (!arst_n)
		clean_valid && clean_keep |->
			(clean_out_byte == CH_TAB || clean_out_byte == CH_LF ||
			clean_out_byte >= CH_SPACE))
		else $error("control byte passed through");

endmodule

bind ansi_escape_stripper_unit aesc_checker u_aesc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.clean_valid    (clean.valid),
	.clean_ready    (clean.ready),
	.clean_keep     (clean.keep),
	.clean_out_byte (clean.out_byte)
);
